// ----- hdl/dmacp_pkg.sv -----
// Package for the port-programmed DMA controller.
// Holds command codes, group codes and small helper functions; no dependencies.
`timescale 1ns / 1ps
package dmacp_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    GRP_WR0     = 3'd0,
    GRP_WR1     = 3'd1,
    GRP_WR2     = 3'd2,
    GRP_DISCARD = 3'd3,
    GRP_WR4     = 3'd4
  } grp_t;

  localparam logic [7:0] CMD_RESET      = 8'hC3;
  localparam logic [7:0] CMD_RESET_A    = 8'hC7;
  localparam logic [7:0] CMD_RESET_B    = 8'hCB;
  localparam logic [7:0] CMD_LOAD       = 8'hCF;
  localparam logic [7:0] CMD_CONTINUE   = 8'hD3;
  localparam logic [7:0] CMD_ENABLE     = 8'h87;
  localparam logic [7:0] CMD_DISABLE    = 8'h83;
  localparam logic [7:0] CMD_RD_STOP    = 8'hBF;
  localparam logic [7:0] CMD_CLR_STATUS = 8'h8B;
  localparam logic [7:0] CMD_RD_INIT    = 8'hA7;
  localparam logic [7:0] CMD_RD_MASK    = 8'hBB;

  localparam logic [1:0] STEP_DEC = 2'd0;
  localparam logic [1:0] STEP_INC = 2'd1;
  localparam logic [2:0] CYC_DEFAULT = 3'd3;
  localparam logic [6:0] RD_MASK_ALL = 7'h7F;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        move_valid;
    logic [15:0] src_addr;
    logic        src_is_io;
    logic [15:0] dst_addr;
    logic        dst_is_io;
    logic [2:0]  src_cycles;
    logic [2:0]  dst_cycles;
    logic        block_done;
  } result_t;

  function automatic logic [2:0] cyc_code(input logic [1:0] bits);
    unique case (bits)
      2'd1:    return 3'd3;
      2'd2:    return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [15:0] step_addr(input logic [15:0] addr, input logic [1:0] step);
    if (step == STEP_DEC) return addr - 16'd1;
    if (step == STEP_INC) return addr + 16'd1;
    return addr;
  endfunction

endpackage

// ----- hdl/dma_controller_port_programmed.sv -----
// Top level: input register, controller core and a two-entry output buffer.
// Items pass the input register and the output buffer; one item per cycle while in_stall is low.
// Reset (rst, synchronous) restores all controller registers and empties both stages.
// Depends on dmacp_pkg and dmacp_core.
`timescale 1ns / 1ps
module dma_controller_port_programmed (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        move_valid,
  output logic [15:0] src_addr,
  output logic        src_is_io,
  output logic [15:0] dst_addr,
  output logic        dst_is_io,
  output logic [2:0]  src_cycles,
  output logic [2:0]  dst_cycles,
  output logic        block_done
);
  import dmacp_pkg::*;

  logic classic_mode;
  logic q_valid;
  logic [1:0] q_func;
  logic [7:0] q_data;
  result_t core_res;
  result_t obuf, skid;
  logic obuf_valid, skid_valid;
  logic go;

  // The skid entry being full stops intake and holds the register stage; the skid entry advances into obuf.
  assign in_stall = skid_valid;
  assign go = q_valid && !(skid_valid || (obuf_valid && out_stall && skid_valid));

  always_ff @(posedge clk) begin
    if (rst) classic_mode <= 1'b0;
    else if (cfg_we) classic_mode <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end else if (go) begin
      q_valid <= 1'b0;
    end
    if (!in_stall) begin
      q_func <= func; q_data <= data;
    end
  end

  dmacp_core u_core (
    .clk(clk), .rst(rst), .classic_mode(classic_mode), .go(go),
    .func(q_func), .data(q_data), .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (!obuf_valid || !out_stall) begin
        if (skid_valid) begin
          obuf <= skid; obuf_valid <= 1'b1; skid_valid <= go;
          if (go) skid <= core_res;
        end else begin
          obuf_valid <= go;
          if (go) obuf <= core_res;
        end
      end else if (go) begin
        skid <= core_res; skid_valid <= 1'b1;
      end
    end
  end

  assign out_valid  = obuf_valid;
  assign read_data  = obuf.read_data;
  assign move_valid = obuf.move_valid;
  assign src_addr   = obuf.src_addr;
  assign src_is_io  = obuf.src_is_io;
  assign dst_addr   = obuf.dst_addr;
  assign dst_is_io  = obuf.dst_is_io;
  assign src_cycles = obuf.src_cycles;
  assign dst_cycles = obuf.dst_cycles;
  assign block_done = obuf.block_done;

endmodule

// ----- hdl/dmacp_core.sv -----
// Controller state and the per-item decode, read and transfer logic.
// Depends on dmacp_pkg.
`timescale 1ns / 1ps
module dmacp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                classic_mode,
  input  logic                go,
  input  logic [1:0]          func,
  input  logic [7:0]          data,
  output dmacp_pkg::result_t  res
);
  import dmacp_pkg::*;

  logic a_to_b, a_io, b_io, restart_on_end, running, started, ended;
  logic in_params, mask_next, prescale_next, rd_seq_on;
  logic [15:0] a_base, b_base, block_len, a_cur, b_cur;
  logic [16:0] remaining;
  logic [1:0] a_step, b_step;
  logic [2:0] a_cyc, b_cyc, param_pos, rd_pos;
  logic [7:0] prescale;
  grp_t param_group;
  logic [3:0] params_left;
  logic [6:0] rd_mask;

  logic a_to_b_next, a_io_next, b_io_next, restart_on_end_next, running_next;
  logic started_next, ended_next, in_params_next, mask_next_next;
  logic prescale_next_next, rd_seq_on_next;
  logic [15:0] a_base_next, b_base_next, block_len_next, a_cur_next, b_cur_next;
  logic [16:0] remaining_next;
  logic [1:0] a_step_next, b_step_next;
  logic [2:0] a_cyc_next, b_cyc_next, param_pos_next, rd_pos_next;
  logic [7:0] prescale_reg_next;
  grp_t param_group_next;
  logic [3:0] params_left_next;
  logic [6:0] rd_mask_next;

  logic [7:0] status;
  assign status = {2'b00, ~ended, 4'b1101, started} & 8'h3B | 8'h1A;

  always_comb begin
    logic [2:0] pos, i;
    logic found;
    logic [16:0] rem_dec;
    a_to_b_next = a_to_b; a_io_next = a_io; b_io_next = b_io;
    restart_on_end_next = restart_on_end; running_next = running;
    started_next = started; ended_next = ended; in_params_next = in_params;
    mask_next_next = mask_next; prescale_next_next = prescale_next;
    rd_seq_on_next = rd_seq_on; a_base_next = a_base; b_base_next = b_base;
    block_len_next = block_len; a_cur_next = a_cur; b_cur_next = b_cur;
    remaining_next = remaining; a_step_next = a_step; b_step_next = b_step;
    a_cyc_next = a_cyc; b_cyc_next = b_cyc; param_pos_next = param_pos;
    rd_pos_next = rd_pos; prescale_reg_next = prescale;
    param_group_next = param_group; params_left_next = params_left;
    rd_mask_next = rd_mask;
    res = '0;
    pos = '0; i = '0; found = 1'b0; rem_dec = remaining - 17'd1;
    unique case (func_t'(func))
      FUNC_WRITE: begin
        if (mask_next) begin
          rd_mask_next = data[6:0]; mask_next_next = 1'b0;
          rd_pos_next = '0; rd_seq_on_next = 1'b1;
        end else if (prescale_next) begin
          prescale_reg_next = data; prescale_next_next = 1'b0; in_params_next = 1'b0;
        end else if (in_params) begin
          // Only bits 0..3 can be pending; positions 4..7 never match.
          for (int k = 3; k >= 0; k--) begin
            if (!found && 3'(k) >= param_pos && params_left[k]) begin
              pos = 3'(k);
            end
          end
          found = 1'b0;
          for (int k = 0; k < 4; k++) begin
            if (3'(k) >= param_pos && params_left[k]) found = 1'b1;
          end
          if (!found) begin
            in_params_next = 1'b0;
          end else begin
            params_left_next = params_left & ~(4'd1 << pos[1:0]);
            param_pos_next = pos + 3'd1;
            if (params_left_next == 4'd0) in_params_next = 1'b0;
            unique case (param_group)
              GRP_WR0: begin
                if (!pos[1]) begin
                  if (pos[0]) a_base_next[15:8] = data; else a_base_next[7:0] = data;
                end else begin
                  if (pos[0]) block_len_next[15:8] = data;
                  else block_len_next[7:0] = data;
                end
              end
              GRP_WR1: begin
                a_cyc_next = cyc_code(data[1:0]);
                if (data[5]) begin
                  prescale_next_next = 1'b0; params_left_next = 4'd1;
                  param_pos_next = '0; param_group_next = GRP_DISCARD;
                  in_params_next = in_params;
                end
              end
              GRP_WR2: begin
                b_cyc_next = cyc_code(data[1:0]);
                if (data[5]) prescale_next_next = 1'b1;
              end
              GRP_WR4: begin
                if (pos[0]) b_base_next[15:8] = data; else b_base_next[7:0] = data;
              end
              default: ;
            endcase
          end
        end else begin
          if ((data & 8'h83) == 8'h83) begin
            unique case (data)
              CMD_RESET: begin
                running_next = 1'b0; started_next = 1'b0; ended_next = 1'b0;
                a_cyc_next = CYC_DEFAULT; b_cyc_next = CYC_DEFAULT;
                prescale_reg_next = '0; restart_on_end_next = 1'b0;
                rd_mask_next = RD_MASK_ALL; in_params_next = 1'b0;
                mask_next_next = 1'b0; prescale_next_next = 1'b0;
                rd_seq_on_next = 1'b0; rd_pos_next = '0;
              end
              CMD_RESET_A: a_cyc_next = CYC_DEFAULT;
              CMD_RESET_B: b_cyc_next = CYC_DEFAULT;
              CMD_LOAD: begin
                a_cur_next = a_base; b_cur_next = b_base;
                remaining_next = {1'b0, block_len} + {16'd0, classic_mode};
                ended_next = 1'b0;
              end
              CMD_CONTINUE: begin
                remaining_next = {1'b0, block_len} + {16'd0, classic_mode};
                ended_next = 1'b0;
              end
              CMD_ENABLE: running_next = 1'b1;
              CMD_DISABLE: running_next = 1'b0;
              CMD_RD_STOP: rd_seq_on_next = 1'b0;
              CMD_CLR_STATUS: begin
                ended_next = 1'b0; started_next = 1'b0;
              end
              CMD_RD_INIT: begin
                rd_pos_next = '0; rd_seq_on_next = 1'b1;
              end
              CMD_RD_MASK: mask_next_next = 1'b1;
              default: ;
            endcase
          end else if ((data & 8'hC7) == 8'h82) begin
            restart_on_end_next = data[5];
          end else if ((data & 8'h83) == 8'h81) begin
            params_left_next = {2'b00, data[3:2]};
            if (data[3:2] != 2'b00) begin
              in_params_next = 1'b1; param_group_next = GRP_WR4; param_pos_next = '0;
            end
          end else if ((data & 8'h83) == 8'h80) begin
            // Mask and match register: no effect.
          end else if ((data & 8'h87) == 8'h04) begin
            a_io_next = data[3]; a_step_next = data[5:4];
            if (data[6]) begin
              params_left_next = 4'd1; in_params_next = 1'b1;
              param_group_next = GRP_WR1; param_pos_next = '0;
            end
          end else if ((data & 8'h87) == 8'h00) begin
            b_io_next = data[3]; b_step_next = data[5:4];
            if (data[6]) begin
              params_left_next = 4'd1; in_params_next = 1'b1;
              param_group_next = GRP_WR2; param_pos_next = '0;
            end
          end else if (!data[7]) begin
            a_to_b_next = data[2];
            params_left_next = data[6:3];
            if (data[6:3] != 4'd0) begin
              in_params_next = 1'b1; param_group_next = GRP_WR0; param_pos_next = '0;
            end
          end
        end
      end
      FUNC_READ: begin
        if (!rd_seq_on) begin
          res.read_data = status;
        end else begin
          // First mask bit at or after rd_pos, else wrap to the first one.
          i = 3'd7;
          for (int k = 6; k >= 0; k--) begin
            if (3'(k) >= rd_pos && rd_mask[k]) i = 3'(k);
          end
          if (i == 3'd7) begin
            for (int k = 6; k >= 0; k--) begin
              if (rd_mask[k]) i = 3'(k);
            end
            rd_pos_next = i;
          end
          if (i == 3'd7) begin
            res.read_data = status;
          end else begin
            unique case (i)
              3'd0: res.read_data = status;
              3'd1: res.read_data = remaining[7:0];
              3'd2: res.read_data = remaining[15:8];
              3'd3: res.read_data = a_cur[7:0];
              3'd4: res.read_data = a_cur[15:8];
              3'd5: res.read_data = b_cur[7:0];
              default: res.read_data = b_cur[15:8];
            endcase
            rd_pos_next = (i == 3'd6) ? 3'd0 : i + 3'd1;
          end
        end
      end
      FUNC_TICK: begin
        if (running) begin
          if (remaining != 17'd0) begin
            started_next = 1'b1;
            res.move_valid = 1'b1;
            if (a_to_b) begin
              res.src_addr = a_cur; res.src_is_io = a_io; res.src_cycles = a_cyc;
              res.dst_addr = b_cur; res.dst_is_io = b_io; res.dst_cycles = b_cyc;
            end else begin
              res.src_addr = b_cur; res.src_is_io = b_io; res.src_cycles = b_cyc;
              res.dst_addr = a_cur; res.dst_is_io = a_io; res.dst_cycles = a_cyc;
            end
            a_cur_next = step_addr(a_cur, a_step);
            b_cur_next = step_addr(b_cur, b_step);
            remaining_next = rem_dec;
          end
          if (remaining == 17'd0 || rem_dec == 17'd0) begin
            ended_next = 1'b1;
            res.block_done = 1'b1;
            if (restart_on_end) begin
              a_cur_next = a_base; b_cur_next = b_base;
              remaining_next = {1'b0, block_len} + {16'd0, classic_mode};
              ended_next = 1'b0;
            end else begin
              running_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_to_b <= 1'b0; a_io <= 1'b0; b_io <= 1'b0; restart_on_end <= 1'b0;
      running <= 1'b0; started <= 1'b0; ended <= 1'b0; in_params <= 1'b0;
      mask_next <= 1'b0; prescale_next <= 1'b0; rd_seq_on <= 1'b0;
      a_base <= '0; b_base <= '0; block_len <= '0; a_cur <= '0; b_cur <= '0;
      remaining <= '0; a_step <= STEP_INC; b_step <= STEP_INC;
      a_cyc <= CYC_DEFAULT; b_cyc <= CYC_DEFAULT; param_pos <= '0; rd_pos <= '0;
      prescale <= '0; param_group <= GRP_WR0; params_left <= '0;
      rd_mask <= RD_MASK_ALL;
    end else if (go) begin
      a_to_b <= a_to_b_next; a_io <= a_io_next; b_io <= b_io_next;
      restart_on_end <= restart_on_end_next; running <= running_next;
      started <= started_next; ended <= ended_next; in_params <= in_params_next;
      mask_next <= mask_next_next; prescale_next <= prescale_next_next;
      rd_seq_on <= rd_seq_on_next; a_base <= a_base_next; b_base <= b_base_next;
      block_len <= block_len_next; a_cur <= a_cur_next; b_cur <= b_cur_next;
      remaining <= remaining_next; a_step <= a_step_next; b_step <= b_step_next;
      a_cyc <= a_cyc_next; b_cyc <= b_cyc_next; param_pos <= param_pos_next;
      rd_pos <= rd_pos_next; prescale <= prescale_reg_next;
      param_group <= param_group_next; params_left <= params_left_next;
      rd_mask <= rd_mask_next;
    end
  end

endmodule
